@@ hdl/nmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Neighbourhood mean filter package
// Shared widths, register codes, pipeline records and the reciprocal table
// used by the 3x3 mean filter.
// ----------------------------------------------------------------------------
package nmf_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_WIDTH       = 1024;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT    = 4096;
   localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
   localparam int WIDTH_CFG_BITS  = 11;
   localparam int HEIGHT_CFG_BITS = 13;
   localparam int WIDTH_RESET     = 1024;
   localparam int HEIGHT_RESET    = 1024;

   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam int COLSUM_BITS     = SAMPLE_BITS + 2;
   localparam int SUM_BITS        = SAMPLE_BITS + 4;
   localparam int MAG_BITS        = SAMPLE_BITS + 3;
   localparam int RECIP_BITS      = 32;
   localparam int PROD_BITS       = MAG_BITS + RECIP_BITS;
   localparam int COUNT_BITS      = 4;

   localparam int RESULTS         = 4;
   localparam int QUEUE_DEPTH     = 8;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int CREDIT_BITS     = QPTR_BITS + 1;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // Result slots of one word: previous row then current row, left column first.
   localparam logic [1:0] SLOT_UP_LEFT = 2'd0;
   localparam logic [1:0] SLOT_UP      = 2'd1;
   localparam logic [1:0] SLOT_LEFT    = 2'd2;
   localparam logic [1:0] SLOT_HERE    = 2'd3;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic [RESULTS-1:0]  mask;
      logic                row_ge1;
      logic                row_ge2;
      logic                col_ge1;
      logic                col_ge2;
   } meta_type;

   typedef struct packed {
      logic [RESULTS-1:0][SAMPLE_BITS-1:0] mean;
      logic [ROW_BITS-1:0]                 row;
      logic [COL_BITS-1:0]                 col;
      logic [RESULTS-1:0]                  mask;
   } bundle_type;

   // Rounded-up reciprocals scaled by 2^32; exact for dividends below 2^19.
   function automatic logic [RECIP_BITS-1:0] nmf_recip(input logic [COUNT_BITS-1:0] count);
      logic [RECIP_BITS-1:0] recip;
      case (count)
         4'd2:    recip = 32'h8000_0000;
         4'd3:    recip = 32'h5555_5556;
         4'd4:    recip = 32'h4000_0000;
         4'd6:    recip = 32'h2AAA_AAAB;
         4'd9:    recip = 32'h1C71_C71D;
         default: recip = '0;
      endcase
      return recip;
   endfunction

endpackage

@@ hdl/neighbourhood_mean_filter.sv @@
// ----------------------------------------------------------------------------
// Neighbourhood mean filter
// 3x3 mean of a raster-order frame of signed samples, averaged over the
// cells that lie inside the frame, with row, column and end-of-frame marks.
//
//   channel   direction   handshake                     word
//   req       in          req_valid / req_stall         sample_in
//   rsp       out         rsp_valid / rsp_stall         mean_out, out_row,
//                                                       out_col, frame_last
//   csr       in/out      psel, penable, pwrite, pready frame_width (0x0),
//                                                       frame_height (0x4)
//
// One sample word can be accepted every clock cycle while req_stall is low;
// each accepted word gives zero to four result words.
// The limit is the eight-group result queue: req_stall is high while eight
// result groups are queued or in flight, which happens only when rsp is
// stalled or in the last row of a frame, where each word after the first
// column gives two or more result words.
// Reset is synchronous; the line stores are not cleared, so no clearing pass.
// ----------------------------------------------------------------------------
module neighbourhood_mean_filter (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [nmf_pkg::SAMPLE_BITS-1:0]  req_sample_in,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [nmf_pkg::SAMPLE_BITS-1:0]  rsp_mean_out,
   output logic [nmf_pkg::ROW_BITS-1:0]            rsp_out_row,
   output logic [nmf_pkg::COL_BITS-1:0]            rsp_out_col,
   output logic                                    rsp_frame_last,

   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [nmf_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [nmf_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [nmf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   logic [nmf_pkg::WIDTH_CFG_BITS-1:0]   width_cfg_ff;
   logic [nmf_pkg::HEIGHT_CFG_BITS-1:0]  height_cfg_ff;
   nmf_pkg::reg_index_type               reg_sel;
   logic                                 csr_write;

   logic [nmf_pkg::COL_BITS-1:0]         width_m1;
   logic [nmf_pkg::ROW_BITS-1:0]         height_m1;
   logic [nmf_pkg::COL_BITS-1:0]         col_ff, col_in;
   logic [nmf_pkg::ROW_BITS-1:0]         row_ff, row_in;
   logic                                 last_col, last_row;
   logic                                 accept;
   nmf_pkg::meta_type                    meta_in;

   logic                                 s1_valid_ff;
   nmf_pkg::meta_type                    s1_meta_ff;
   logic [nmf_pkg::SAMPLE_BITS-1:0]      s1_sample_ff;

   logic [nmf_pkg::SAMPLE_BITS-1:0]      line_upper, line_middle;
   logic                                 s2_valid;
   nmf_pkg::meta_type                    s2_meta;
   logic [2:0][nmf_pkg::COLSUM_BITS-1:0] s2_sum_a, s2_sum_b;
   logic                                 grp_valid;
   nmf_pkg::bundle_type                  grp_bundle;
   logic                                 queue_full;

   assign reg_sel    = nmf_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_sel)
         nmf_pkg::REG_FRAME_WIDTH:  csr_prdata = nmf_pkg::CSR_DATA_BITS'(width_cfg_ff);
         nmf_pkg::REG_FRAME_HEIGHT: csr_prdata = nmf_pkg::CSR_DATA_BITS'(height_cfg_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= nmf_pkg::WIDTH_CFG_BITS'(nmf_pkg::WIDTH_RESET);
         height_cfg_ff <= nmf_pkg::HEIGHT_CFG_BITS'(nmf_pkg::HEIGHT_RESET);
      end else if (csr_write) begin
         case (reg_sel)
            nmf_pkg::REG_FRAME_WIDTH: begin
               width_cfg_ff <= csr_pwdata[nmf_pkg::WIDTH_CFG_BITS-1:0];
            end
            nmf_pkg::REG_FRAME_HEIGHT: begin
               height_cfg_ff <= csr_pwdata[nmf_pkg::HEIGHT_CFG_BITS-1:0];
            end
            default: begin
               width_cfg_ff <= width_cfg_ff;
            end
         endcase
      end
   end

   // A zero size counts as one; oversize values saturate at MAX_WIDTH and HEIGHT_LIMIT.
   always_comb begin
      if (width_cfg_ff == '0) begin
         width_m1 = '0;
      end else if (width_cfg_ff > nmf_pkg::WIDTH_CFG_BITS'(nmf_pkg::MAX_WIDTH)) begin
         width_m1 = nmf_pkg::COL_BITS'(nmf_pkg::MAX_WIDTH - 1);
      end else begin
         width_m1 = nmf_pkg::COL_BITS'(width_cfg_ff - nmf_pkg::WIDTH_CFG_BITS'(1));
      end
      if (height_cfg_ff == '0) begin
         height_m1 = '0;
      end else if (height_cfg_ff > nmf_pkg::HEIGHT_CFG_BITS'(nmf_pkg::HEIGHT_LIMIT)) begin
         height_m1 = nmf_pkg::ROW_BITS'(nmf_pkg::HEIGHT_LIMIT - 1);
      end else begin
         height_m1 = nmf_pkg::ROW_BITS'(height_cfg_ff - nmf_pkg::HEIGHT_CFG_BITS'(1));
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      last_col        = (col_ff == width_m1);
      last_row        = (row_ff == height_m1);
      meta_in.row     = row_ff;
      meta_in.col     = col_ff;
      meta_in.row_ge1 = (row_ff != '0);
      meta_in.row_ge2 = (row_ff > nmf_pkg::ROW_BITS'(1));
      meta_in.col_ge1 = (col_ff != '0);
      meta_in.col_ge2 = (col_ff > nmf_pkg::COL_BITS'(1));
      meta_in.mask[nmf_pkg::SLOT_UP_LEFT] = meta_in.row_ge1 && meta_in.col_ge1;
      meta_in.mask[nmf_pkg::SLOT_UP]      = meta_in.row_ge1 && last_col;
      meta_in.mask[nmf_pkg::SLOT_LEFT]    = last_row && meta_in.col_ge1;
      meta_in.mask[nmf_pkg::SLOT_HERE]    = last_row && last_col;

      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + nmf_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + nmf_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff   <= meta_in;
         s1_sample_ff <= req_sample_in;
      end
   end

   nmf_line_store u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_meta_ff.col),
      .wr_sample (s1_sample_ff),
      .upper     (line_upper),
      .middle    (line_middle)
   );

   nmf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_meta   (s1_meta_ff),
      .in_sample (s1_sample_ff),
      .in_upper  (line_upper),
      .in_middle (line_middle),
      .out_valid (s2_valid),
      .out_meta  (s2_meta),
      .out_sum_a (s2_sum_a),
      .out_sum_b (s2_sum_b)
   );

   nmf_mean u_mean (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_meta    (s2_meta),
      .in_sum_a   (s2_sum_a),
      .in_sum_b   (s2_sum_b),
      .out_valid  (grp_valid),
      .out_bundle (grp_bundle)
   );

   nmf_out_queue u_out_queue (
      .clock          (clock),
      .reset          (reset),
      .reserve        (accept && (meta_in.mask != '0)),
      .push           (grp_valid && (grp_bundle.mask != '0)),
      .push_bundle    (grp_bundle),
      .full           (queue_full),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_out   (rsp_mean_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

@@ hdl/nmf_line_store.sv @@
// ----------------------------------------------------------------------------
// Line store
// Holds the two previous rows of the frame. Reads are registered; a read
// that hits the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module nmf_line_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [nmf_pkg::COL_BITS-1:0]     rd_addr,
   input  logic                             wr_en,
   input  logic [nmf_pkg::COL_BITS-1:0]     wr_addr,
   input  logic [nmf_pkg::SAMPLE_BITS-1:0]  wr_sample,
   output logic [nmf_pkg::SAMPLE_BITS-1:0]  upper,
   output logic [nmf_pkg::SAMPLE_BITS-1:0]  middle
);

   logic [nmf_pkg::SAMPLE_BITS-1:0] upper_mem  [nmf_pkg::MAX_WIDTH];
   logic [nmf_pkg::SAMPLE_BITS-1:0] middle_mem [nmf_pkg::MAX_WIDTH];

   logic [nmf_pkg::SAMPLE_BITS-1:0] upper_rd_ff;
   logic [nmf_pkg::SAMPLE_BITS-1:0] middle_rd_ff;
   logic [nmf_pkg::SAMPLE_BITS-1:0] upper_byp_ff;
   logic [nmf_pkg::SAMPLE_BITS-1:0] middle_byp_ff;
   logic                            byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= middle;
         middle_mem[wr_addr] <= wr_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_rd_ff   <= upper_mem[rd_addr];
         middle_rd_ff  <= middle_mem[rd_addr];
         upper_byp_ff  <= middle;
         middle_byp_ff <= wr_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign upper  = byp_ff ? upper_byp_ff  : upper_rd_ff;
   assign middle = byp_ff ? middle_byp_ff : middle_rd_ff;

endmodule

@@ hdl/nmf_window.sv @@
// ----------------------------------------------------------------------------
// Window and column sums
// Keeps the two previous columns of the three rows, blanks cells outside the
// frame and forms registered column sums for both result rows.
// ----------------------------------------------------------------------------
module nmf_window (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  nmf_pkg::meta_type                             in_meta,
   input  logic [nmf_pkg::SAMPLE_BITS-1:0]               in_sample,
   input  logic [nmf_pkg::SAMPLE_BITS-1:0]               in_upper,
   input  logic [nmf_pkg::SAMPLE_BITS-1:0]               in_middle,
   output logic                                          out_valid,
   output nmf_pkg::meta_type                             out_meta,
   output logic [2:0][nmf_pkg::COLSUM_BITS-1:0]          out_sum_a,
   output logic [2:0][nmf_pkg::COLSUM_BITS-1:0]          out_sum_b
);

   // win_ff[row][0] is column C-1, win_ff[row][1] is column C-2.
   logic [2:0][1:0][nmf_pkg::SAMPLE_BITS-1:0] win_ff, win_in;
   logic [2:0][2:0][nmf_pkg::SAMPLE_BITS-1:0] tap;
   logic signed [nmf_pkg::COLSUM_BITS-1:0]    ext [3][3];
   logic [2:0][nmf_pkg::COLSUM_BITS-1:0]      sum_a_in, sum_b_in;
   logic [2:0]                                row_ok, col_ok;

   logic                                      valid_ff;
   nmf_pkg::meta_type                         meta_ff;
   logic [2:0][nmf_pkg::COLSUM_BITS-1:0]      sum_a_ff, sum_b_ff;

   always_comb begin
      row_ok = {1'b1, in_meta.row_ge1, in_meta.row_ge2};
      col_ok = {1'b1, in_meta.col_ge1, in_meta.col_ge2};
      for (int i = 0; i < 3; i++) begin
         tap[i][1] = win_ff[i][0];
         tap[i][0] = win_ff[i][1];
      end
      tap[0][2] = in_upper;
      tap[1][2] = in_middle;
      tap[2][2] = in_sample;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j]) begin
               ext[i][j] = nmf_pkg::COLSUM_BITS'($signed(tap[i][j]));
            end else begin
               ext[i][j] = '0;
            end
         end
      end
      for (int j = 0; j < 3; j++) begin
         sum_b_in[j] = ext[1][j] + ext[2][j];
         sum_a_in[j] = ext[0][j] + ext[1][j] + ext[2][j];
      end
      win_in = win_ff;
      if (in_valid) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][1] = win_ff[i][0];
            win_in[i][0] = tap[i][2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         meta_ff  <= in_meta;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_sum_a = sum_a_ff;
   assign out_sum_b = sum_b_ff;

endmodule

@@ hdl/nmf_mean.sv @@
// ----------------------------------------------------------------------------
// Mean datapath
// Adds the column sums into up to four neighbourhood sums, divides each by
// its cell count with a reciprocal multiply and restores the sign.
// ----------------------------------------------------------------------------
module nmf_mean (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  nmf_pkg::meta_type                      in_meta,
   input  logic [2:0][nmf_pkg::COLSUM_BITS-1:0]   in_sum_a,
   input  logic [2:0][nmf_pkg::COLSUM_BITS-1:0]   in_sum_b,
   output logic                                   out_valid,
   output nmf_pkg::bundle_type                    out_bundle
);

   logic signed [nmf_pkg::SUM_BITS-1:0]   sum      [nmf_pkg::RESULTS];
   logic [nmf_pkg::MAG_BITS-1:0]          mag_in   [nmf_pkg::RESULTS];
   logic [nmf_pkg::RESULTS-1:0]           neg_in;
   logic [nmf_pkg::COUNT_BITS-1:0]        cnt_in   [nmf_pkg::RESULTS];
   logic [1:0]                            rows_up, rows_here, cols_left, cols_here;
   logic [nmf_pkg::PROD_BITS-1:0]         prod     [nmf_pkg::RESULTS];
   logic [nmf_pkg::MAG_BITS-1:0]          quot_in  [nmf_pkg::RESULTS];

   logic                                  s3_valid_ff;
   nmf_pkg::meta_type                     s3_meta_ff;
   logic [nmf_pkg::MAG_BITS-1:0]          s3_mag_ff [nmf_pkg::RESULTS];
   logic [nmf_pkg::RESULTS-1:0]           s3_neg_ff;
   logic [nmf_pkg::COUNT_BITS-1:0]        s3_cnt_ff [nmf_pkg::RESULTS];

   logic                                  s4_valid_ff;
   nmf_pkg::meta_type                     s4_meta_ff;
   logic [nmf_pkg::MAG_BITS-1:0]          s4_quot_ff [nmf_pkg::RESULTS];
   logic [nmf_pkg::RESULTS-1:0]           s4_neg_ff;

   always_comb begin
      sum[nmf_pkg::SLOT_UP_LEFT] = nmf_pkg::SUM_BITS'($signed(in_sum_a[0]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_a[1]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_a[2]));
      sum[nmf_pkg::SLOT_UP]      = nmf_pkg::SUM_BITS'($signed(in_sum_a[1]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_a[2]));
      sum[nmf_pkg::SLOT_LEFT]    = nmf_pkg::SUM_BITS'($signed(in_sum_b[0]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_b[1]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_b[2]));
      sum[nmf_pkg::SLOT_HERE]    = nmf_pkg::SUM_BITS'($signed(in_sum_b[1]))
                                 + nmf_pkg::SUM_BITS'($signed(in_sum_b[2]));

      rows_up   = in_meta.row_ge2 ? 2'd3 : 2'd2;
      rows_here = in_meta.row_ge1 ? 2'd2 : 2'd1;
      cols_left = in_meta.col_ge2 ? 2'd3 : 2'd2;
      cols_here = in_meta.col_ge1 ? 2'd2 : 2'd1;
      cnt_in[nmf_pkg::SLOT_UP_LEFT] = nmf_pkg::COUNT_BITS'(rows_up)
                                    * nmf_pkg::COUNT_BITS'(cols_left);
      cnt_in[nmf_pkg::SLOT_UP]      = nmf_pkg::COUNT_BITS'(rows_up)
                                    * nmf_pkg::COUNT_BITS'(cols_here);
      cnt_in[nmf_pkg::SLOT_LEFT]    = nmf_pkg::COUNT_BITS'(rows_here)
                                    * nmf_pkg::COUNT_BITS'(cols_left);
      cnt_in[nmf_pkg::SLOT_HERE]    = nmf_pkg::COUNT_BITS'(rows_here)
                                    * nmf_pkg::COUNT_BITS'(cols_here);

      for (int k = 0; k < nmf_pkg::RESULTS; k++) begin
         neg_in[k] = sum[k][nmf_pkg::SUM_BITS-1];
         mag_in[k] = nmf_pkg::MAG_BITS'(neg_in[k] ? -sum[k] : sum[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < nmf_pkg::RESULTS; k++) begin
         prod[k] = nmf_pkg::PROD_BITS'(s3_mag_ff[k])
                 * nmf_pkg::PROD_BITS'(nmf_pkg::nmf_recip(s3_cnt_ff[k]));
         if (s3_cnt_ff[k] == nmf_pkg::COUNT_BITS'(1)) begin
            quot_in[k] = s3_mag_ff[k];
         end else begin
            quot_in[k] = prod[k][nmf_pkg::PROD_BITS-1:nmf_pkg::RECIP_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_meta_ff <= in_meta;
      s3_neg_ff  <= neg_in;
      s4_meta_ff <= s3_meta_ff;
      s4_neg_ff  <= s3_neg_ff;
      for (int k = 0; k < nmf_pkg::RESULTS; k++) begin
         s3_mag_ff[k]  <= mag_in[k];
         s3_cnt_ff[k]  <= cnt_in[k];
         s4_quot_ff[k] <= quot_in[k];
      end
   end

   always_comb begin
      out_bundle.row  = s4_meta_ff.row;
      out_bundle.col  = s4_meta_ff.col;
      out_bundle.mask = s4_meta_ff.mask;
      for (int k = 0; k < nmf_pkg::RESULTS; k++) begin
         out_bundle.mean[k] = nmf_pkg::SAMPLE_BITS'(s4_neg_ff[k]
                              ? nmf_pkg::MAG_BITS'(0) - s4_quot_ff[k]
                              : s4_quot_ff[k]);
      end
   end

   assign out_valid = s4_valid_ff;

endmodule

@@ hdl/nmf_out_queue.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Buffers the result groups of accepted words and hands out their results one
// word at a time in slot order. Credits cover groups still in flight.
// ----------------------------------------------------------------------------
module nmf_out_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    reserve,
   input  logic                                    push,
   input  nmf_pkg::bundle_type                     push_bundle,
   output logic                                    full,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [nmf_pkg::SAMPLE_BITS-1:0]  rsp_mean_out,
   output logic [nmf_pkg::ROW_BITS-1:0]            rsp_out_row,
   output logic [nmf_pkg::COL_BITS-1:0]            rsp_out_col,
   output logic                                    rsp_frame_last
);

   nmf_pkg::bundle_type               q_ff [nmf_pkg::QUEUE_DEPTH];
   logic [nmf_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [nmf_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [nmf_pkg::CREDIT_BITS-1:0]   count_ff, count_in;
   logic [nmf_pkg::CREDIT_BITS-1:0]   credit_ff, credit_in;
   logic [nmf_pkg::RESULTS-1:0]       done_ff, done_in;

   nmf_pkg::bundle_type               head;
   logic [nmf_pkg::RESULTS-1:0]       pending;
   logic [nmf_pkg::RESULTS-1:0]       slot_bit;
   logic [1:0]                        slot;
   logic                              pop;
   logic                              retire;

   always_comb begin
      head    = q_ff[rd_ptr_ff];
      pending = head.mask & ~done_ff;
      if (pending[nmf_pkg::SLOT_UP_LEFT]) begin
         slot = nmf_pkg::SLOT_UP_LEFT;
      end else if (pending[nmf_pkg::SLOT_UP]) begin
         slot = nmf_pkg::SLOT_UP;
      end else if (pending[nmf_pkg::SLOT_LEFT]) begin
         slot = nmf_pkg::SLOT_LEFT;
      end else begin
         slot = nmf_pkg::SLOT_HERE;
      end
      slot_bit = nmf_pkg::RESULTS'(1) << slot;

      rsp_valid = (count_ff != '0);
      pop       = rsp_valid && !rsp_stall;
      retire    = pop && ((pending & ~slot_bit) == '0);

      wr_ptr_in = push   ? wr_ptr_ff + nmf_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = retire ? rd_ptr_ff + nmf_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + nmf_pkg::CREDIT_BITS'(push)
                           - nmf_pkg::CREDIT_BITS'(retire);
      credit_in = credit_ff + nmf_pkg::CREDIT_BITS'(reserve)
                            - nmf_pkg::CREDIT_BITS'(retire);
      if (retire) begin
         done_in = '0;
      end else if (pop) begin
         done_in = done_ff | slot_bit;
      end else begin
         done_in = done_ff;
      end

      full           = (credit_ff == nmf_pkg::CREDIT_BITS'(nmf_pkg::QUEUE_DEPTH));
      rsp_mean_out   = $signed(head.mean[slot]);
      rsp_out_row    = head.row - nmf_pkg::ROW_BITS'(slot == nmf_pkg::SLOT_UP_LEFT
                                                   || slot == nmf_pkg::SLOT_UP);
      rsp_out_col    = head.col - nmf_pkg::COL_BITS'(slot == nmf_pkg::SLOT_UP_LEFT
                                                   || slot == nmf_pkg::SLOT_LEFT);
      rsp_frame_last = (slot == nmf_pkg::SLOT_HERE);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
         done_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
         done_ff   <= done_in;
      end
   end

   a_count_within_credit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= credit_ff)
      else $error("Queue holds more result groups than were reserved.");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != nmf_pkg::CREDIT_BITS'(nmf_pkg::QUEUE_DEPTH)) || retire)
      else $error("Result group pushed into a full queue.");

   a_head_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending != '0))
      else $error("Queue head has no results left to deliver.");

   a_retire_clears: assert property (@(posedge clock) disable iff (reset)
      retire |=> (done_ff == '0))
      else $error("Delivered-result mask not cleared after a group retired.");

endmodule
